>>> hdl/tlf_pkg.sv
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants for the text line folder
// Character codes, fold column limits and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlf_pkg;

   localparam int CHAR_W = 8;
   localparam int FOLD_W = 6;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

   localparam logic [FOLD_W-1:0] FOLD_SAT   = 6'd62;
   localparam logic [FOLD_W-1:0] FOLD_RESET = 6'd59;

   // controller to datapath
   typedef struct packed {
      logic accept;     // input transfer: append byte, update word state
      logic plan;       // latch emit length, trailing newline and fold kind
      logic emit_load;  // load output register from the line store
      logic emit_nl;    // load output register with an inserted newline
      logic idx_inc;
      logic idx_clr;
      logic shift_sel;  // read the store at break point plus index
      logic shift_wr;   // write the carried byte to the front
      logic finish;     // commit fill, word flag and break point
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_nl;
      logic over;
      logic more;
      logic tail;
      logic shift_more;
      logic out_free;
   } status_type;

endpackage

>>> hdl/text_line_folder_unit.sv
// ----------------------------------------------------------------------------
// text_line_folder_unit: greedy word-wrap line folder
// Buffers a text line and emits it on newline or when it exceeds the fold
// column, breaking at the last blank after a word, or at the full line if none.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one text byte per transfer (req_in_char).
//   rsp_*  : emitted bytes; rsp_run_end marks the last byte caused by one
//            input byte. Bytes that cause no output produce no transfer.
//   csr_*  : write fold_column; always ready, write only while idle.
// Sequence: a byte that emits nothing is appended and planned. A byte that
//   ends a line then drains its stored bytes one by one; a fold adds the
//   inserted newline and the shift check, plus a copy of a carried word.
//   The drain and the carried-word copy both go through the single
//   registered-read port of the line store.
// Reset clears fill, word flag and break point and restores fold column 59;
//   the line store needs no clearing. When the receiver stalls, the output
//   register holds its byte and the sequencer waits; no input is taken until
//   the current byte's results have all been loaded.
// ----------------------------------------------------------------------------
module text_line_folder_unit #(
   parameter int LINE_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tlf_pkg::CHAR_W-1:0]  req_in_char,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tlf_pkg::CHAR_W-1:0]  rsp_out_char,
   output logic                        rsp_run_end,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tlf_pkg::FOLD_W-1:0]  csr_fold_column
);

   tlf_pkg::cmd_type    cmd;
   tlf_pkg::status_type status;

   assign csr_ready = 1'b1;

   tlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlf_datapath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_char   (req_in_char),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_fold_column),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_char  (rsp_out_char),
      .out_end   (rsp_run_end)
   );

endmodule

>>> hdl/tlf_datapath.sv
// ----------------------------------------------------------------------------
// tlf_datapath: line store, counters and output register
// Holds the current line in a single-port-write, registered-read memory,
// tracks fill, word flag and break point, and drives the result register.
// ----------------------------------------------------------------------------
module tlf_datapath #(
   parameter int LINE_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tlf_pkg::cmd_type            cmd,
   output tlf_pkg::status_type         status,
   input  logic [tlf_pkg::CHAR_W-1:0]  in_char,
   input  logic                        csr_we,
   input  logic [tlf_pkg::FOLD_W-1:0]  csr_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [tlf_pkg::CHAR_W-1:0]  out_char,
   output logic                        out_end
);

   localparam int CW    = $clog2(LINE_DEPTH);
   localparam int CMP_W = (CW > tlf_pkg::FOLD_W) ? CW : tlf_pkg::FOLD_W;
   localparam int CAP_I = (LINE_DEPTH - 2 < 62) ? LINE_DEPTH - 2 : 62;
   localparam logic [tlf_pkg::FOLD_W-1:0] FOLD_CAP = tlf_pkg::FOLD_W'(CAP_I);

   logic [tlf_pkg::CHAR_W-1:0] store_mem [LINE_DEPTH];
   logic [tlf_pkg::CHAR_W-1:0] rd_data_ff;

   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] bp_ff, bp_in;
   logic          word_ff, word_in;
   logic          nl_ff, nl_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic          tail_ff, tail_in;
   logic          soft_ff, soft_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [tlf_pkg::FOLD_W-1:0] fold_ff, fold_in;
   logic          out_valid_ff, out_valid_in;
   logic [tlf_pkg::CHAR_W-1:0] out_char_ff, out_char_in;
   logic          out_end_ff, out_end_in;

   logic                       blank, nl;
   logic [tlf_pkg::FOLD_W-1:0] eff_fold;
   logic [CW-1:0]              rd_addr, wr_addr;
   logic [tlf_pkg::CHAR_W-1:0] wr_data;
   logic                       wr_en;
   logic [CW:0]                src_pos;

   assign blank    = (in_char == tlf_pkg::CH_SPACE) || (in_char == tlf_pkg::CH_TAB);
   assign nl       = (in_char == tlf_pkg::CH_NL);
   assign eff_fold = (fold_ff > FOLD_CAP) ? FOLD_CAP : fold_ff;
   assign src_pos  = {1'b0, bp_ff} + {1'b0, idx_ff};

   assign rd_addr = cmd.shift_sel ? src_pos[CW-1:0] : idx_ff;
   assign wr_en   = cmd.accept || cmd.shift_wr;
   assign wr_addr = cmd.accept ? fill_ff : idx_ff;
   assign wr_data = cmd.accept ? in_char : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_comb begin
      status.is_nl      = nl_ff;
      status.over       = CMP_W'(fill_ff) > CMP_W'(eff_fold);
      status.more       = idx_ff < lim_ff;
      status.tail       = tail_ff;
      status.shift_more = soft_ff && (src_pos < {1'b0, fill_ff});
      status.out_free   = !out_valid_ff || out_ready;
   end

   always_comb begin
      fill_in      = fill_ff;
      bp_in        = bp_ff;
      word_in      = word_ff;
      nl_in        = nl_ff;
      lim_in       = lim_ff;
      tail_in      = tail_ff;
      soft_in      = soft_ff;
      idx_in       = idx_ff;
      fold_in      = fold_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_end_in   = out_end_ff;

      if (csr_we) begin
         fold_in = csr_data;
      end

      if (cmd.accept) begin
         fill_in = fill_ff + 1'b1;
         nl_in   = nl;
         if (word_ff && blank) begin
            bp_in   = fill_ff + 1'b1;
            word_in = 1'b0;
         end else if (!word_ff && !blank && !nl) begin
            word_in = 1'b1;
         end
      end

      if (cmd.plan) begin
         idx_in = '0;
         if (nl_ff) begin
            lim_in  = fill_ff;
            tail_in = 1'b0;
            soft_in = 1'b0;
         end else if (bp_ff == '0) begin
            lim_in  = fill_ff;
            tail_in = 1'b1;
            soft_in = 1'b0;
         end else begin
            lim_in  = bp_ff - 1'b1;
            tail_in = 1'b1;
            soft_in = 1'b1;
         end
      end

      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      // drop the output once the receiver takes it, then maybe reload
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit_load) begin
         out_valid_in = 1'b1;
         out_char_in  = rd_data_ff;
         out_end_in   = !tail_ff && (idx_ff == lim_ff - 1'b1);
      end else if (cmd.emit_nl) begin
         out_valid_in = 1'b1;
         out_char_in  = tlf_pkg::CH_NL;
         out_end_in   = 1'b1;
      end

      if (cmd.finish) begin
         bp_in = '0;
         if (nl_ff) begin
            fill_in = '0;
            word_in = 1'b0;
         end else if (soft_ff) begin
            fill_in = fill_ff - bp_ff;
         end else begin
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         bp_ff        <= '0;
         word_ff      <= 1'b0;
         nl_ff        <= 1'b0;
         lim_ff       <= '0;
         tail_ff      <= 1'b0;
         soft_ff      <= 1'b0;
         idx_ff       <= '0;
         fold_ff      <= tlf_pkg::FOLD_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         bp_ff        <= bp_in;
         word_ff      <= word_in;
         nl_ff        <= nl_in;
         lim_ff       <= lim_in;
         tail_ff      <= tail_in;
         soft_ff      <= soft_in;
         idx_ff       <= idx_in;
         fold_ff      <= fold_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_end_ff  <= out_end_in;
   end

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_end   = out_end_ff;

endmodule

>>> hdl/tlf_ctrl.sv
// ----------------------------------------------------------------------------
// tlf_ctrl: sequencing controller for the text line folder
// Steps one input byte through append, plan, emit, newline insertion,
// carried-word shift and commit.
// ----------------------------------------------------------------------------
module tlf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tlf_pkg::status_type  status,
   output tlf_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMIT_NL,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (status.is_nl || status.over) begin
               cmd.plan = 1'b1;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            if (status.more) begin
               state_in = ST_EMIT_OUT;
            end else if (status.tail) begin
               state_in = ST_EMIT_NL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EMIT_OUT: begin
            // hold until the output register frees up
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_EMIT_NL: begin
            if (status.out_free) begin
               cmd.emit_nl = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            cmd.shift_sel = 1'b1;
            if (status.shift_more) begin
               state_in = ST_SHIFT_WR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> dv/text_line_folder_unit_test.sv
// ----------------------------------------------------------------------------
// text_line_folder_unit_test: self-checking bench for the line folder
// Drives text bytes, fold column writes and a stalling receiver. Each accepted
// byte goes through a local word-wrap predictor, and every emitted byte is
// checked against the oldest predicted byte, including its run_end flag.
// ----------------------------------------------------------------------------
module text_line_folder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 64;
   localparam int SETTLE_CYCLES = 4 * LINE_DEPTH + 4;

   typedef struct packed {
      logic [tlf_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } emitted_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [tlf_pkg::CHAR_W-1:0] req_in_char = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [tlf_pkg::CHAR_W-1:0] rsp_out_char;
   logic                       rsp_run_end;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [tlf_pkg::FOLD_W-1:0] csr_fold_column = '0;

   // predicted line state
   emitted_type                emit_q[$];
   logic [tlf_pkg::CHAR_W-1:0] line_buf [LINE_DEPTH];
   int                         line_fill = 0;
   int                         brk_pos = 0;
   logic                       word_open = 1'b0;
   logic [tlf_pkg::FOLD_W-1:0] fold_col = tlf_pkg::FOLD_RESET;

   int errors = 0;
   int bytes_in = 0;
   int bytes_out = 0;
   int fold_writes = 0;
   int rsp_hold_left = 0;
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;

   text_line_folder_unit #(.LINE_DEPTH(LINE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_char     (req_in_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_end     (rsp_run_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_fold_column (csr_fold_column)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int fold_limit();
      int f;
      f = fold_col;
      if (f > tlf_pkg::FOLD_SAT) f = tlf_pkg::FOLD_SAT;
      if (f > LINE_DEPTH - 2) f = LINE_DEPTH - 2;
      return f;
   endfunction

   // Append one byte and queue whatever the line emits because of it.
   task automatic predict_line(input logic [tlf_pkg::CHAR_W-1:0] c);
      bit          blank;
      bit          nl;
      int          i;
      int          carry;
      int          start;
      emitted_type tail;
      blank = (c == tlf_pkg::CH_SPACE) || (c == tlf_pkg::CH_TAB);
      nl = (c == tlf_pkg::CH_NL);
      start = emit_q.size();
      if (line_fill < LINE_DEPTH) line_buf[line_fill] = c;
      line_fill++;
      if (word_open && blank) begin
         brk_pos = line_fill;
         word_open = 1'b0;
      end else if (!word_open && !blank && !nl) begin
         word_open = 1'b1;
      end
      if (nl) begin
         for (i = 0; i < line_fill && i < LINE_DEPTH; i++)
            emit_q.push_back('{ch: line_buf[i], last: 1'b0});
         line_fill = 0;
         word_open = 1'b0;
         brk_pos = 0;
      end else if (line_fill > fold_limit()) begin
         if (brk_pos == 0 || brk_pos > line_fill) begin
            // hard break: whole buffer, then a newline; word flag is kept
            for (i = 0; i < line_fill && i < LINE_DEPTH; i++)
               emit_q.push_back('{ch: line_buf[i], last: 1'b0});
            emit_q.push_back('{ch: tlf_pkg::CH_NL, last: 1'b0});
            line_fill = 0;
         end else begin
            carry = line_fill - brk_pos;
            for (i = 0; i + 1 < brk_pos && i < LINE_DEPTH; i++)
               emit_q.push_back('{ch: line_buf[i], last: 1'b0});
            emit_q.push_back('{ch: tlf_pkg::CH_NL, last: 1'b0});
            // move the partial word to the front
            for (i = 0; i < carry && brk_pos + i < LINE_DEPTH; i++)
               line_buf[i] = line_buf[brk_pos + i];
            line_fill = carry;
         end
         brk_pos = 0;
      end
      if (emit_q.size() > start) begin
         tail = emit_q.pop_back();
         tail.last = 1'b1;
         emit_q.push_back(tail);
      end
   endtask

   // Check the result transfer first, then predict from the input transfer.
   always @(posedge clock) begin : check_and_predict
      emitted_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            bytes_out++;
            if (emit_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte, expected none, actual %h run_end %b",
                        $time, rsp_out_char, rsp_run_end);
            end else begin
               want = emit_q.pop_front();
               if (rsp_out_char !== want.ch) begin
                  errors++;
                  $display("%0t: out_char expected %h, actual %h",
                           $time, want.ch, rsp_out_char);
               end
               if (rsp_run_end !== want.last) begin
                  errors++;
                  $display("%0t: run_end expected %b, actual %b",
                           $time, want.last, rsp_run_end);
               end
            end
         end
         if (req_valid && req_ready) begin
            bytes_in++;
            predict_line(req_in_char);
         end
         if (csr_valid && csr_ready) fold_col = csr_fold_column;
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(rsp_gaps && $urandom_range(0, 99) < 27);
         end
      end
   end

   task automatic send_char(input logic [tlf_pkg::CHAR_W-1:0] c);
      @(negedge clock);
      while (req_gaps && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_char <= c;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold until every predicted byte has come out.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (emit_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_fold(input logic [tlf_pkg::FOLD_W-1:0] v);
      drain_results();
      // a carried-word copy may still run after the last byte
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_fold_column <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      fold_writes++;
   endtask

   function automatic logic [tlf_pkg::CHAR_W-1:0] word_char();
      logic [tlf_pkg::CHAR_W-1:0] c;
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h21, 8'h7e));
      if (c == tlf_pkg::CH_SPACE || c == tlf_pkg::CH_TAB || c == tlf_pkg::CH_NL) c = 8'h7a;
      return c;
   endfunction

   // Words of random bytes split by blanks, with newlines and stray bytes.
   task automatic send_random_text(input int count, input int nl_pct);
      int sent;
      int len;
      int k;
      int roll;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < nl_pct) begin
            send_char(tlf_pkg::CH_NL);
            sent++;
         end else if (roll < nl_pct + 8) begin
            send_char(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 8);
            for (k = 0; k < len && sent < count; k++) begin
               send_char(word_char());
               sent++;
            end
            len = $urandom_range(1, 3);
            for (k = 0; k < len && sent < count; k++) begin
               send_char($urandom_range(0, 1) ? tlf_pkg::CH_SPACE : tlf_pkg::CH_TAB);
               sent++;
            end
         end
      end
   endtask

   // Reset fold column, field extremes, zero byte, both blanks, newline.
   task automatic test_directed_bytes();
      send_char("a");
      send_char(8'h00);
      send_char(8'hff);
      send_char(tlf_pkg::CH_TAB);
      send_char(tlf_pkg::CH_SPACE);
      send_char("b");
      send_char(tlf_pkg::CH_NL);
   endtask

   // Column 0 folds after every byte; column 3 shows a soft and a hard break.
   task automatic test_tiny_columns();
      write_fold(6'd0);
      send_char("x");
      send_char(tlf_pkg::CH_SPACE);
      send_char("y");
      send_char(tlf_pkg::CH_NL);
      write_fold(6'd3);
      send_char("a");
      send_char("b");
      send_char(tlf_pkg::CH_SPACE);
      send_char("c");
      send_char("d");
      send_char(tlf_pkg::CH_NL);
      send_char("a");
      send_char("b");
      send_char("c");
      send_char("d");
      send_char("e");
      send_char(tlf_pkg::CH_NL);
   endtask

   task automatic test_random_columns();
      write_fold(6'd2);
      send_random_text(25, 10);
      // above the saturation point
      write_fold(6'd63);
      send_random_text(70, 2);
      write_fold(6'd0);
      send_random_text(20, 10);
      write_fold(6'd1);
      send_random_text(20, 10);
      write_fold(6'd9);
      send_random_text(30, 6);
      write_fold(6'($urandom_range(0, 63)));
      send_random_text(30, 5);
   endtask

   task automatic test_full_rate();
      write_fold(6'd62);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      send_random_text(50, 2);
      drain_results();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   task automatic test_backpressure();
      write_fold(6'd30);
      send_random_text(10, 4);
      // stall the receiver while bytes keep coming; 40 bytes past column 30
      // force at least one emitting byte, so the input backs up
      rsp_hold_left = 400;
      send_random_text(40, 4);
      drain_results();
      send_random_text(5, 4);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_bytes();
      test_tiny_columns();
      test_random_columns();
      test_full_rate();
      test_backpressure();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("tb: %0d text bytes sent, %0d folded bytes checked", bytes_in, bytes_out);
      $display("tb: %0d fold column writes from 0 to 63, with stalls on both sides",
               fold_writes);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/tlf_pkg.sv
hdl/tlf_datapath.sv
hdl/tlf_ctrl.sv
hdl/text_line_folder_unit.sv
dv/text_line_folder_unit_test.sv
